// File: rtl/core/sha256_hash_engine_assert.svh
// Assertion macros used by the SHA-256 engine checker.
`ifndef SHA256_HASH_ENGINE_ASSERT_SVH
`define SHA256_HASH_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define SHA256_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define SHA256_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/sha256_pkg.sv
// Constants, types and round functions of the SHA-256 hash engine.
package sha256_pkg;

  localparam int NUM_ROUNDS  = 64;
  localparam int BLOCK_WORDS = 16;
  localparam int OUT_WORDS   = 8;
  localparam int RND_W       = $clog2(NUM_ROUNDS);
  localparam int WCNT_W      = $clog2(BLOCK_WORDS);
  localparam int OUT_IDX_W   = $clog2(OUT_WORDS);

  localparam logic [7:0] PAD_BYTE = 8'h80;
  // Word positions of the two length words inside the final block.
  localparam logic [WCNT_W-1:0] LEN_HI_POS = WCNT_W'(BLOCK_WORDS - 2);
  localparam logic [WCNT_W-1:0] LEN_LO_POS = WCNT_W'(BLOCK_WORDS - 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ROUND  = 6'b000010,
    ST_UPDATE = 6'b000100,
    ST_PAD    = 6'b001000,
    ST_LEN    = 6'b010000,
    ST_OUT    = 6'b100000
  } sha_state_t;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TABLE [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// File: rtl/core/sha256_hash_engine.sv
// SHA-256 hash engine: byte packing, padding, round sequencer and digest output.
// Each accepted word enters the block; a full 16-word block then runs 64 rounds on the
// one shared round unit and a hash update, and no word is taken until that is done. A
// last word adds the pad word, zero fill and high length word per padded block, the low
// length word and one or two compressions; then eight digest words follow, at best one
// per cycle while m_tready is high.
// Reset (rst, synchronous, active high) loads the initial hash and empties the block.
module sha256_hash_engine
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Message words in.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] data_word
  input  logic [2:0]  s_tuser,   // [2:0] valid_bytes
  input  logic        s_tlast,   // last word of the message
  // Digest words out.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic        m_tlast    // eighth digest word
);

  // The block lives in a 16-word shift register: words enter at the top and the
  // oldest word sits at position zero. During compression the same register
  // serves as the message schedule window, so all of its taps are fixed.
  sha_state_t state, state_next;

  logic [31:0] w     [BLOCK_WORDS];
  logic [31:0] hash  [8];
  logic [31:0] vars  [8];

  logic [WCNT_W-1:0]    wcnt;       // whole words held in the block
  logic [31:0]          acc;        // partial word, bytes left-aligned, unused bytes zero
  logic [1:0]           accn;       // bytes held in acc
  logic [60:0]          msg_bytes;
  logic [RND_W-1:0]     rnd;
  logic [OUT_IDX_W-1:0] out_idx;
  logic                 last_pend;  // the message ended; padding still to come
  logic                 pad_done;   // the 0x80 byte has been placed
  logic                 final_blk;  // the block being compressed holds the length

  // Input byte packing.
  logic [2:0]  n_sat;
  logic [31:0] data_masked;
  logic [55:0] combined;
  logic [2:0]  total;

  // Block fill and schedule shift.
  logic        fill_push;
  logic        shift_en;
  logic [31:0] shift_word;

  // Round unit.
  logic [31:0] t1, t2, sched_new;
  logic [63:0] bit_len;

  logic in_acc;
  logic out_acc;
  logic out_end;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;
  assign out_end = out_acc && (out_idx == OUT_IDX_W'(OUT_WORDS - 1));

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = hash[0];
  assign m_tlast  = (out_idx == OUT_IDX_W'(OUT_WORDS - 1));

  assign bit_len = {msg_bytes, 3'b000};

  // Byte counts above four are treated as four.
  always_comb begin
    n_sat = (s_tuser > 3'd4) ? 3'd4 : s_tuser;
    unique case (n_sat)
      3'd0:    data_masked = 32'h0;
      3'd1:    data_masked = {s_tdata[31:24], 24'h0};
      3'd2:    data_masked = {s_tdata[31:16], 16'h0};
      3'd3:    data_masked = {s_tdata[31:8], 8'h0};
      default: data_masked = s_tdata;
    endcase
    combined = {acc, 24'h0} | ({data_masked, 24'h0} >> {accn, 3'b000});
    total    = {1'b0, accn} + n_sat;
  end

  // One SHA-256 round on the working variables, plus the next schedule word.
  always_comb begin
    t1 = vars[7] + big_sig1(vars[4]) + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6]))
       + K_TABLE[rnd] + w[0];
    t2 = big_sig0(vars[0])
       + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));
    sched_new = w[0] + small_sig0(w[1]) + w[9] + small_sig1(w[14]);
  end

  // What enters the top of the block register this cycle.
  always_comb begin
    fill_push  = 1'b0;
    shift_word = sched_new;
    unique case (state)
      ST_IDLE: begin
        fill_push  = in_acc && (total >= 3'd4);
        shift_word = combined[55:24];
      end
      ST_PAD: begin
        fill_push = 1'b1;
        if (!pad_done) begin
          shift_word = acc | ({PAD_BYTE, 24'h0} >> {accn, 3'b000});
        end else if (wcnt == LEN_HI_POS) begin
          shift_word = bit_len[63:32];
        end else begin
          shift_word = 32'h0;
        end
      end
      ST_LEN: begin
        fill_push  = 1'b1;
        shift_word = bit_len[31:0];
      end
      default: begin
        fill_push  = 1'b0;
        shift_word = sched_new;
      end
    endcase
    shift_en = fill_push || (state == ST_ROUND);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if ((total >= 3'd4) && (wcnt == LEN_LO_POS)) begin
            state_next = ST_ROUND;
          end else if (s_tlast) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (rnd == RND_W'(NUM_ROUNDS - 1)) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!last_pend) begin
          state_next = ST_IDLE;
        end else if (final_blk) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (wcnt == LEN_LO_POS) begin
          state_next = ST_ROUND;
        end else if (pad_done && (wcnt == LEN_HI_POS)) begin
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        state_next = ST_ROUND;
      end
      ST_OUT: begin
        if (out_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Block and schedule register; no reset, every word is written before use.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        w[i] <= w[i + 1];
      end
      w[BLOCK_WORDS - 1] <= shift_word;
    end
  end

  // Working variables: loaded from the hash when a block fills, then one round a cycle.
  always_ff @(posedge clk) begin
    if (fill_push && (wcnt == LEN_LO_POS)) begin
      vars <= hash;
    end else if (state == ST_ROUND) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hash      <= HASH_IV;
      wcnt      <= '0;
      acc       <= '0;
      accn      <= '0;
      msg_bytes <= '0;
      rnd       <= '0;
      out_idx   <= '0;
      last_pend <= 1'b0;
      pad_done  <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      state <= state_next;
      if (fill_push) begin
        wcnt <= wcnt + 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          rnd <= '0;
          if (in_acc) begin
            msg_bytes <= msg_bytes + 61'(n_sat);
            last_pend <= s_tlast;
            pad_done  <= 1'b0;
            final_blk <= 1'b0;
            if (total >= 3'd4) begin
              acc  <= {combined[23:0], 8'h0};
              accn <= 2'(total - 3'd4);
            end else begin
              acc  <= combined[55:24];
              accn <= total[1:0];
            end
          end
        end
        ST_ROUND: begin
          rnd <= rnd + 1'b1;
        end
        ST_UPDATE: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + vars[i];
          end
        end
        ST_PAD: begin
          rnd <= '0;
          if (!pad_done) begin
            pad_done <= 1'b1;
            acc      <= '0;
            accn     <= '0;
          end
        end
        ST_LEN: begin
          rnd       <= '0;
          final_blk <= 1'b1;
        end
        ST_OUT: begin
          if (out_end) begin
            // Digest delivered: start a fresh message.
            hash      <= HASH_IV;
            msg_bytes <= '0;
            out_idx   <= '0;
            last_pend <= 1'b0;
            final_blk <= 1'b0;
          end else if (out_acc) begin
            for (int i = 0; i < 7; i++) begin
              hash[i] <= hash[i + 1];
            end
            hash[7] <= hash[0];
            out_idx <= out_idx + 1'b1;
          end
        end
        default: begin
          rnd <= '0;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/sha256_chk.sv
// Port-level checker for the SHA-256 hash engine and its bind statement.
`include "sha256_hash_engine_assert.svh"

module sha256_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  logic        in_acc;
  logic        out_acc;
  logic        out_stall;
  logic [33:0] out_word;

  assign in_acc    = s_tvalid && s_tready;
  assign out_acc   = m_tvalid && m_tready;
  assign out_stall = m_tvalid && !m_tready;
  assign out_word  = {m_tvalid, m_tlast, m_tdata};

  // Input and output are never open in the same cycle.
  `SHA256_ASSERT_NOW(a_one_side, m_tvalid, !s_tready, "input open during digest")

  // A word that does not end the message never produces a digest word next.
  `SHA256_ASSERT_NEXT(a_no_early_digest, in_acc && !s_tlast, !m_tvalid, "early digest word")

  // A stalled digest word holds its value and its end marker.
  `SHA256_ASSERT_NEXT(a_out_hold, out_stall, $stable(out_word), "stalled digest word changed")

  // Digest words come back to back until the marked one, with input held off.
  `SHA256_ASSERT_NEXT(a_digest_run, out_acc && !m_tlast, m_tvalid && !s_tready, "run broken")

  // Once the final digest word leaves, the engine takes a new message at once.
  `SHA256_ASSERT_NEXT(a_ready_after, out_acc && m_tlast, s_tready && !m_tvalid, "not ready")

endmodule

bind sha256_hash_engine sha256_chk u_sha256_chk (.*);
